// ===== src/ccdp_pkg.sv =====
package ccdp_pkg;

	localparam int MAX_STAGES_DEF = 32;
	localparam int MAX_MEM_DEF    = 255;
	localparam int TIME_BITS_DEF  = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_BUDGET   = 1'b1;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_RUN   = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [5:0]  stage;
		logic [31:0] fwd_time;
		logic [31:0] bwd_time;
		logic [7:0]  act_size;
		logic [7:0]  full_size;
		logic [7:0]  fwd_tmp;
		logic [7:0]  bwd_tmp;
		logic [7:0]  mem_level;
		logic [5:0]  span_first;
		logic [5:0]  span_last;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [31:0] cost;
		logic        infinite;
		logic        use_chain;
		logic [5:0]  leaf_stage;
	} rsp_t;

	typedef struct packed {
		logic [7:0] act;
		logic [7:0] full;
		logic [7:0] ftmp;
		logic [7:0] btmp;
	} size_rec_t;

	typedef enum logic [2:0] {
		STG_LOAD,
		STG_I,
		STG_I1,
		STG_K,
		STG_J
	} stg_sel_t;

	typedef enum logic [2:0] {
		TBL_QUERY,
		TBL_T1,
		TBL_T2,
		TBL_C1,
		TBL_C2
	} tbl_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_QRD,
		ST_D0_A,
		ST_D0_B,
		ST_D0_C,
		ST_D0_W,
		ST_ENT,
		ST_FL_ISS,
		ST_FL_CAP,
		ST_FL_CHK,
		ST_JP_ISS,
		ST_JP_CAP,
		ST_J_ISS,
		ST_J_CAP,
		ST_T1_ISS,
		ST_T1_CAP,
		ST_T2_CAP,
		ST_J_CMP,
		ST_J_NEXT,
		ST_CH_ISS,
		ST_CH_CAP1,
		ST_CH_CAP2,
		ST_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		stg_sel_t stg_sel;
		tbl_sel_t tbl_sel;
		logic     load_we;
		logic     run_init;
		logic     d0_next;
		logic     cap_hi;
		logic     cap_lo;
		logic     wr_diag;
		logic     ent_init;
		logic     cap_k;
		logic     fl_chk;
		logic     cap_prev_ft;
		logic     cap_j;
		logic     cap_t1;
		logic     cap_t2;
		logic     cmp_j;
		logic     j_next;
		logic     cap_chain;
		logic     wr_ent;
		logic     run_done;
		logic     q_start;
		logic     rsp_zero;
		logic     rsp_query;
	} cmd_t;

	typedef struct packed {
		logic diag_last;
		logic m_last;
		logic k_last;
		logic feasible;
		logic m_ge_a;
		logic j_last;
		logic m_ge_fs;
		logic run_last;
	} status_t;

endpackage

// ===== src/ccdp_ctrl.sv =====
module ccdp_ctrl
	import ccdp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  func_t   req_func,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_ready && req_valid;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_zero || cmd.rsp_query)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_func == FUNC_RUN)
						state_d = ST_D0_A;
					else if (req_func == FUNC_QUERY)
						state_d = ST_QRD;
				end
			end
			ST_QRD:    state_d = ST_IDLE;
			ST_D0_A:   state_d = ST_D0_B;
			ST_D0_B:   state_d = ST_D0_C;
			ST_D0_C:   state_d = ST_D0_W;
			ST_D0_W:   state_d = (st.diag_last && st.m_last) ? ST_ENT : ST_D0_A;
			ST_ENT:    state_d = ST_FL_ISS;
			ST_FL_ISS: state_d = ST_FL_CAP;
			ST_FL_CAP: state_d = st.k_last ? ST_FL_CHK : ST_FL_ISS;
			ST_FL_CHK: state_d = st.feasible ? ST_JP_ISS : ST_WR;
			ST_JP_ISS: state_d = ST_JP_CAP;
			ST_JP_CAP: state_d = ST_J_ISS;
			ST_J_ISS:  state_d = ST_J_CAP;
			ST_J_CAP:  state_d = st.m_ge_a ? ST_T1_ISS : ST_J_NEXT;
			ST_T1_ISS: state_d = ST_T1_CAP;
			ST_T1_CAP: state_d = ST_T2_CAP;
			ST_T2_CAP: state_d = ST_J_CMP;
			ST_J_CMP:  state_d = ST_J_NEXT;
			ST_J_NEXT: state_d = st.j_last ? ST_CH_ISS : ST_J_ISS;
			ST_CH_ISS: state_d = st.m_ge_fs ? ST_CH_CAP1 : ST_WR;
			ST_CH_CAP1: state_d = ST_CH_CAP2;
			ST_CH_CAP2: state_d = ST_WR;
			ST_WR:     state_d = st.run_last ? ST_DONE : ST_ENT;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.stg_sel = STG_LOAD;
		cmd.tbl_sel = TBL_QUERY;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_func)
						FUNC_LOAD: begin
							cmd.load_we  = 1'b1;
							cmd.rsp_zero = 1'b1;
						end
						FUNC_RUN:   cmd.run_init = 1'b1;
						FUNC_QUERY: cmd.q_start  = 1'b1;
						default:    cmd.rsp_zero = 1'b1;
					endcase
				end
			end
			ST_QRD:  cmd.rsp_query = 1'b1;
			ST_D0_A: cmd.stg_sel = STG_I1;
			ST_D0_B: begin
				cmd.stg_sel = STG_I;
				cmd.cap_hi  = 1'b1;
			end
			ST_D0_C: cmd.cap_lo = 1'b1;
			ST_D0_W: begin
				cmd.wr_diag = 1'b1;
				cmd.d0_next = 1'b1;
			end
			ST_ENT:    cmd.ent_init = 1'b1;
			ST_FL_ISS: cmd.stg_sel = STG_K;
			ST_FL_CAP: cmd.cap_k = 1'b1;
			ST_FL_CHK: cmd.fl_chk = 1'b1;
			ST_JP_ISS: cmd.stg_sel = STG_I;
			ST_JP_CAP: cmd.cap_prev_ft = 1'b1;
			ST_J_ISS:  cmd.stg_sel = STG_J;
			ST_J_CAP:  cmd.cap_j = 1'b1;
			ST_T1_ISS: cmd.tbl_sel = TBL_T1;
			ST_T1_CAP: begin
				cmd.cap_t1  = 1'b1;
				cmd.tbl_sel = TBL_T2;
			end
			ST_T2_CAP: cmd.cap_t2 = 1'b1;
			ST_J_CMP:  cmd.cmp_j = 1'b1;
			ST_J_NEXT: cmd.j_next = !st.j_last;
			ST_CH_ISS: cmd.tbl_sel = TBL_C1;
			ST_CH_CAP1: begin
				cmd.cap_t1  = 1'b1;
				cmd.tbl_sel = TBL_C2;
			end
			ST_CH_CAP2: cmd.cap_chain = 1'b1;
			ST_WR:      cmd.wr_ent = 1'b1;
			ST_DONE: begin
				cmd.run_done = 1'b1;
				cmd.rsp_zero = 1'b1;
			end
			default: cmd.rsp_zero = 1'b0;
		endcase
	end

endmodule

// ===== src/ccdp_dp.sv =====
module ccdp_dp
	import ccdp_pkg::*;
#(
	parameter int MAX_STAGES = MAX_STAGES_DEF,
	parameter int MAX_MEM    = MAX_MEM_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output status_t               st
);

	localparam int STRIDE = MAX_STAGES + 1;
	localparam int DEPTH  = MAX_STAGES + 2;
	localparam int TSIZE  = (MAX_MEM + 1) * STRIDE * STRIDE;
	localparam int IW     = $clog2(STRIDE);
	localparam int SW     = $clog2(DEPTH);
	localparam int MW     = $clog2(MAX_MEM + 1);
	localparam int AW     = $clog2(TSIZE);
	localparam int CW     = TIME_BITS + 1;
	localparam int FLW    = 10;
	localparam int CMPW   = ((MW > FLW) ? MW : FLW) + 1;
	localparam int OW     = (CW > 32) ? CW : 33;
	localparam logic [CW-1:0] INF = {1'b1, {TIME_BITS{1'b0}}};

	function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, INF})
			return INF;
		return s[CW-1:0];
	endfunction

	function automatic logic [AW-1:0] tidx(logic [MW-1:0] m, logic [IW-1:0] i,
		logic [IW-1:0] l);
		return AW'(m) * AW'(STRIDE * STRIDE) + AW'(i) * AW'(STRIDE) + AW'(l);
	endfunction

	// configuration and run bookkeeping
	logic [5:0]    chain_len_q;
	logic [7:0]    mem_budget_q;
	logic          run_valid_q;
	logic [IW-1:0] run_len_q;
	logic [MW-1:0] run_mem_q;

	// loop counters
	logic [MW-1:0] m_q, mm_q;
	logic [IW-1:0] i_q, d_q, j_q, n_q, l_w;
	logic [SW-1:0] k_q;

	// stage stores
	logic [2*CW-1:0] tm_mem [DEPTH];
	size_rec_t       sz_mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [2*CW-1:0] tm_rd_q;
	size_rec_t       sz_rd_q;
	logic            rd_vld_q;
	logic [SW-1:0]   stg_addr;
	logic [CW-1:0]   ft_r, bt_r;
	size_rec_t       sz_r;
	logic [CW-1:0]   ld_ft, ld_bt;

	// tables
	logic [CW+IW-1:0] tbl_mem [TSIZE];
	logic [CW+IW-1:0] tbl_rd_q;
	logic [CW+IW-1:0] tbl_wdata;
	logic [AW-1:0]    tbl_raddr, tbl_waddr;
	logic             tbl_we;
	logic [CW-1:0]    rd_cost;
	logic [IW-1:0]    rd_ch;

	// per-entry working registers
	size_rec_t     hi_q, lo_q, prev_q;
	logic [CW-1:0] lo_ft_q, lo_bt_q;
	logic [8:0]    base_q;
	logic [FLW-1:0] worst_q;
	logic [7:0]    top_q, fs_q, aj_q;
	logic [CW-1:0] prev_ft_q, sum_q, t1_q, tsum_q, best_q, chain_q;
	logic [IW-1:0] bj_q;
	logic          q_bad_q, q_long_q;

	logic [FLW-1:0] fl_a, fl_b, fl_max, term;
	logic [8:0]     d0_base;
	logic           d0_ok;
	logic [CW-1:0]  c_j;
	logic [MW-1:0]  m_sub_a, m_sub_fs;
	logic           q_bad;

	assign l_w = i_q + d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_len_q  <= 6'd1;
			mem_budget_q <= 8'd255;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CHAIN_LENGTH)
				chain_len_q <= cfg_data[5:0];
			else if (cfg_index == CFG_MEM_BUDGET)
				mem_budget_q <= cfg_data[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_len_q   <= '0;
			run_mem_q   <= '0;
			m_q         <= '0;
			mm_q        <= '0;
			i_q         <= '0;
			d_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
		end else begin
			if (cmd.run_init) begin
				if (chain_len_q == '0)
					n_q <= IW'(1);
				else if (16'(chain_len_q) > 16'(MAX_STAGES))
					n_q <= IW'(MAX_STAGES);
				else
					n_q <= IW'(chain_len_q);
				if (16'(mem_budget_q) > 16'(MAX_MEM))
					mm_q <= MW'(MAX_MEM);
				else
					mm_q <= MW'(mem_budget_q);
				m_q <= '0;
				i_q <= '0;
			end
			if (cmd.d0_next) begin
				if (i_q == n_q) begin
					i_q <= '0;
					if (m_q == mm_q) begin
						m_q <= '0;
						d_q <= IW'(1);
					end else begin
						m_q <= m_q + MW'(1);
					end
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			if (cmd.wr_ent) begin
				if (l_w == n_q) begin
					i_q <= '0;
					if (d_q == n_q) begin
						d_q <= IW'(1);
						m_q <= m_q + MW'(1);
					end else begin
						d_q <= d_q + IW'(1);
					end
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			if (cmd.ent_init)
				k_q <= SW'(i_q);
			else if (cmd.cap_k)
				k_q <= k_q + SW'(1);
			if (cmd.fl_chk)
				j_q <= i_q + IW'(1);
			else if (cmd.j_next)
				j_q <= j_q + IW'(1);
			if (cmd.run_done) begin
				run_valid_q <= 1'b1;
				run_len_q   <= n_q;
				run_mem_q   <= mm_q;
			end
		end
	end

	// stage store: valid bits make unloaded entries read as zero
	always_comb begin
		case (cmd.stg_sel)
			STG_I:   stg_addr = SW'(i_q);
			STG_I1:  stg_addr = SW'(i_q) + SW'(1);
			STG_K:   stg_addr = k_q;
			STG_J:   stg_addr = SW'(j_q);
			default: stg_addr = SW'(req.stage);
		endcase
	end

	assign ld_ft = (64'(req.fwd_time) >= (64'd1 << TIME_BITS)) ? INF : CW'(req.fwd_time);
	assign ld_bt = (64'(req.bwd_time) >= (64'd1 << TIME_BITS)) ? INF : CW'(req.bwd_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (cmd.load_we && (16'(req.stage) < 16'(DEPTH)))
			vld_q[SW'(req.stage)] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		tm_rd_q  <= tm_mem[stg_addr];
		sz_rd_q  <= sz_mem[stg_addr];
		rd_vld_q <= vld_q[stg_addr];
		if (cmd.load_we && (16'(req.stage) < 16'(DEPTH))) begin
			tm_mem[SW'(req.stage)] <= {ld_ft, ld_bt};
			sz_mem[SW'(req.stage)] <= {req.act_size, req.full_size, req.fwd_tmp,
				req.bwd_tmp};
		end
	end

	assign ft_r = rd_vld_q ? tm_rd_q[2*CW-1:CW] : '0;
	assign bt_r = rd_vld_q ? tm_rd_q[CW-1:0] : '0;
	assign sz_r = rd_vld_q ? sz_rd_q : '0;

	// table access
	assign m_sub_a  = MW'(CMPW'(m_q) - CMPW'(aj_q));
	assign m_sub_fs = MW'(CMPW'(m_q) - CMPW'(fs_q));

	always_comb begin
		case (cmd.tbl_sel)
			TBL_T1:  tbl_raddr = tidx(m_sub_a, j_q, l_w);
			TBL_T2:  tbl_raddr = tidx(m_q, i_q, j_q - IW'(1));
			TBL_C1:  tbl_raddr = tidx(m_q, i_q, i_q);
			TBL_C2:  tbl_raddr = tidx(m_sub_fs, i_q + IW'(1), l_w);
			default: tbl_raddr = tidx(MW'(req.mem_level), IW'(req.span_first),
				IW'(req.span_last));
		endcase
	end

	assign d0_base = 9'(hi_q.act) + 9'(hi_q.full);
	assign d0_ok   = (CMPW'(m_q) >= CMPW'(d0_base) + CMPW'(lo_q.btmp)) &&
		(CMPW'(m_q) >= CMPW'(d0_base) + CMPW'(lo_q.ftmp));

	always_comb begin
		tbl_we    = cmd.wr_diag || cmd.wr_ent;
		tbl_waddr = cmd.wr_diag ? tidx(m_q, i_q, i_q) : tidx(m_q, i_q, l_w);
		if (cmd.wr_diag)
			tbl_wdata = {(d0_ok ? sat_add(lo_ft_q, lo_bt_q) : INF), {IW{1'b0}}};
		else if (best_q <= chain_q)
			tbl_wdata = {best_q, bj_q};
		else
			tbl_wdata = {chain_q, {IW{1'b0}}};
	end

	always_ff @(posedge clk) begin
		tbl_rd_q <= tbl_mem[tbl_raddr];
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
	end

	assign rd_cost = tbl_rd_q[CW+IW-1:IW];
	assign rd_ch   = tbl_rd_q[IW-1:0];

	// memory floor of the span
	assign term   = FLW'(prev_q.act) + FLW'(sz_r.act) + FLW'(prev_q.ftmp);
	assign fl_a   = FLW'(top_q) + FLW'(base_q);
	assign fl_b   = FLW'(top_q) + worst_q;
	assign fl_max = (fl_a > fl_b) ? fl_a : fl_b;
	assign c_j    = sat_add(sum_q, tsum_q);

	always_ff @(posedge clk) begin
		if (cmd.cap_hi)
			hi_q <= sz_r;
		if (cmd.cap_lo) begin
			lo_q    <= sz_r;
			lo_ft_q <= ft_r;
			lo_bt_q <= bt_r;
		end
		if (cmd.ent_init)
			worst_q <= '0;
		if (cmd.cap_k) begin
			if (k_q == SW'(i_q) + SW'(1)) begin
				base_q <= 9'(sz_r.act) + 9'(prev_q.ftmp);
				fs_q   <= sz_r.full;
			end
			if ((k_q >= SW'(i_q) + SW'(2)) && (k_q <= SW'(l_w)) && (term > worst_q))
				worst_q <= term;
			if (k_q == SW'(l_w) + SW'(1))
				top_q <= sz_r.act;
			prev_q <= sz_r;
		end
		if (cmd.fl_chk) begin
			best_q  <= INF;
			bj_q    <= '0;
			chain_q <= INF;
			sum_q   <= '0;
		end
		if (cmd.cap_prev_ft)
			prev_ft_q <= ft_r;
		if (cmd.cap_j) begin
			aj_q      <= sz_r.act;
			sum_q     <= sat_add(sum_q, prev_ft_q);
			prev_ft_q <= ft_r;
		end
		if (cmd.cap_t1)
			t1_q <= rd_cost;
		if (cmd.cap_t2)
			tsum_q <= sat_add(t1_q, rd_cost);
		// first j of least cost wins
		if (cmd.cmp_j && (c_j < best_q)) begin
			best_q <= c_j;
			bj_q   <= j_q;
		end
		if (cmd.cap_chain)
			chain_q <= sat_add(t1_q, rd_cost);
	end

	// query check and response register
	assign q_bad = !run_valid_q || (16'(req.mem_level) > 16'(run_mem_q)) ||
		(16'(req.span_last) > 16'(run_len_q)) || (req.span_first > req.span_last);

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			q_bad_q  <= q_bad;
			q_long_q <= req.span_last > req.span_first;
		end
		if (cmd.rsp_zero) begin
			rsp <= '0;
		end else if (cmd.rsp_query) begin
			if (q_bad_q) begin
				rsp        <= '0;
				rsp.status <= 1'b1;
			end else begin
				rsp.status     <= 1'b0;
				rsp.cost       <= (OW'(rd_cost) >= OW'(33'h0FFFFFFFF)) ? 32'hFFFFFFFF :
					32'(rd_cost);
				rsp.infinite   <= rd_cost >= INF;
				rsp.use_chain  <= q_long_q && (rd_ch == '0);
				rsp.leaf_stage <= 6'(rd_ch);
			end
		end
	end

	assign st.diag_last = i_q == n_q;
	assign st.m_last    = m_q == mm_q;
	assign st.k_last    = k_q == SW'(l_w) + SW'(1);
	assign st.feasible  = CMPW'(m_q) >= CMPW'(fl_max);
	assign st.m_ge_a    = CMPW'(m_q) >= CMPW'(sz_r.act);
	assign st.j_last    = j_q == l_w;
	assign st.m_ge_fs   = CMPW'(m_q) >= CMPW'(fs_q);
	assign st.run_last  = (l_w == n_q) && (d_q == n_q) && (m_q == mm_q);

endmodule

// ===== src/checkpoint_chain_dp_solver.sv =====
// Optimal checkpointing table solver for a chain of stages.
// Request channel (req_valid/req_ready/req) carries one of three functions:
// load writes the times and memory sizes of one stage, run fills the cost
// and choice tables for every memory level up to mem_budget and every span
// of the chain, query reads one table entry. Every request yields exactly
// one response on rsp_valid/rsp_ready/rsp.
// Timing: a load (or an unknown function) answers in the cycle after it is
// taken, and loads can follow back to back while rsp_ready is high; a query
// reads the table in the QRD state and answers from the response register.
// A run holds the request channel for the whole table fill of every memory
// level and span, as the sequencer walks the table memory through its one
// read port.
// The user writes chain_length and mem_budget via cfg_we/cfg_index/cfg_data
// while the block is idle (not enforced); they are clamped when a run starts.
// Reset clears the stage stores (through per-entry valid bits, no clearing
// pass), the run history and the control state; tables are undefined until
// a run writes them. A stalled response holds in the output register and
// the request channel waits until it is taken or is being taken.
module checkpoint_chain_dp_solver
	import ccdp_pkg::*;
#(
	parameter int MAX_STAGES = MAX_STAGES_DEF,
	parameter int MAX_MEM    = MAX_MEM_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	ccdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ccdp_dp #(
		.MAX_STAGES (MAX_STAGES),
		.MAX_MEM    (MAX_MEM),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// ===== src/ccdp_checker.sv =====
module ccdp_checker
	import ccdp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response slot is blocked");

	a_load_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.func != FUNC_RUN && req.func != FUNC_QUERY
		|=> rsp_valid)
		else $error("load response missing");

	a_query_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.func == FUNC_QUERY |=> !req_ready ##1 rsp_valid)
		else $error("query response timing wrong");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.func == FUNC_RUN |=> !req_ready && !rsp_valid)
		else $error("run did not hold the request channel");

endmodule

bind checkpoint_chain_dp_solver ccdp_checker u_ccdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
